>>> hw/rtl/expression_language_tokenizer_unit_assert.svh
// Assertion macros shared by the tokenizer RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef EXPRESSION_LANGUAGE_TOKENIZER_UNIT_ASSERT_SVH
`define EXPRESSION_LANGUAGE_TOKENIZER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Plain check on every clock edge.
`define ELTU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define ELTU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define ELTU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ELTU_ASSERT(label, prop, msg)
`define ELTU_ASSERT_IMP(label, ante, cons, msg)
`define ELTU_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> hw/rtl/eltu_pkg.sv
package eltu_pkg;

	localparam int DEF_LINE_BITS     = 16;
	localparam int DEF_COLUMN_BITS   = 16;
	localparam int DEF_OFFSET_BITS   = 32;
	localparam int DEF_KEYWORD_CHARS = 5;

	// token tags
	localparam logic [4:0] TAG_EOI      = 5'd0;
	localparam logic [4:0] TAG_PLUS     = 5'd1;
	localparam logic [4:0] TAG_MINUS    = 5'd2;
	localparam logic [4:0] TAG_ARROW    = 5'd3;
	localparam logic [4:0] TAG_STAR     = 5'd4;
	localparam logic [4:0] TAG_SLASH    = 5'd5;
	localparam logic [4:0] TAG_ASSIGN   = 5'd6;
	localparam logic [4:0] TAG_EQEQ     = 5'd7;
	localparam logic [4:0] TAG_LT       = 5'd8;
	localparam logic [4:0] TAG_LE       = 5'd9;
	localparam logic [4:0] TAG_GT       = 5'd10;
	localparam logic [4:0] TAG_GE       = 5'd11;
	localparam logic [4:0] TAG_NE       = 5'd12;
	localparam logic [4:0] TAG_LPAREN   = 5'd13;
	localparam logic [4:0] TAG_RPAREN   = 5'd14;
	localparam logic [4:0] TAG_COMMA    = 5'd15;
	localparam logic [4:0] TAG_INT      = 5'd16;
	localparam logic [4:0] TAG_IDENT    = 5'd17;
	localparam logic [4:0] TAG_LET      = 5'd18;
	localparam logic [4:0] TAG_IN       = 5'd19;
	localparam logic [4:0] TAG_IF       = 5'd20;
	localparam logic [4:0] TAG_THEN     = 5'd21;
	localparam logic [4:0] TAG_ELSE     = 5'd22;
	localparam logic [4:0] TAG_BOOL_LIT = 5'd23;
	localparam logic [4:0] TAG_AND      = 5'd24;
	localparam logic [4:0] TAG_OR       = 5'd25;
	localparam logic [4:0] TAG_NOT      = 5'd26;
	localparam logic [4:0] TAG_FUN      = 5'd27;
	localparam logic [4:0] TAG_I32      = 5'd28;
	localparam logic [4:0] TAG_BOOL     = 5'd29;
	localparam logic [4:0] TAG_VOID     = 5'd30;
	localparam logic [4:0] TAG_ERROR    = 5'd31;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_of_input;
	} src_item_t;

	typedef struct packed {
		logic [4:0]  token_tag;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic [31:0] start_offset;
		logic [15:0] token_length;
		logic        last_of_run;
	} token_t;

	// up to two tokens per scanned transaction, slot 0 first
	typedef struct packed {
		logic [1:0]       count;
		token_t [1:0]     tok;
	} scan_res_t;

	// Keyword lookup on the first five characters (char 0 in the low byte).
	function automatic logic [4:0] kw_tag(input logic [39:0] pfx, input logic [15:0] len);
		logic [39:0] be;
		logic [4:0]  tag;
		be  = {pfx[7:0], pfx[15:8], pfx[23:16], pfx[31:24], pfx[39:32]};
		tag = TAG_IDENT;
		case (len)
			16'd2: begin
				if (be[39:24] == "in") tag = TAG_IN;
				else if (be[39:24] == "if") tag = TAG_IF;
				else if (be[39:24] == "or") tag = TAG_OR;
			end
			16'd3: begin
				if (be[39:16] == "let") tag = TAG_LET;
				else if (be[39:16] == "and") tag = TAG_AND;
				else if (be[39:16] == "not") tag = TAG_NOT;
				else if (be[39:16] == "fun") tag = TAG_FUN;
				else if (be[39:16] == "i32") tag = TAG_I32;
			end
			16'd4: begin
				if (be[39:8] == "then") tag = TAG_THEN;
				else if (be[39:8] == "else") tag = TAG_ELSE;
				else if (be[39:8] == "true") tag = TAG_BOOL_LIT;
				else if (be[39:8] == "bool") tag = TAG_BOOL;
				else if (be[39:8] == "void") tag = TAG_VOID;
			end
			16'd5: begin
				if (be == "false") tag = TAG_BOOL_LIT;
			end
			default: tag = TAG_IDENT;
		endcase
		return tag;
	endfunction

endpackage

>>> hw/rtl/expression_language_tokenizer_unit.sv
// Flow: a source byte accepted into the input register is scanned once the
//   result queue has room; its tokens go into the result queue, which drives
//   tok_valid from its registered count.
// Throughput: one transaction per cycle while the queue has room; a two-token
//   result is presented one token at a time from the four-entry result queue.
// Reset: arst_n clears position to line 1 column 1 offset 0, drops any pending
//   token and error halt, and empties the input register and result queue.
`include "expression_language_tokenizer_unit_assert.svh"

module expression_language_tokenizer_unit #(
	parameter int LINE_BITS     = eltu_pkg::DEF_LINE_BITS,
	parameter int COLUMN_BITS   = eltu_pkg::DEF_COLUMN_BITS,
	parameter int OFFSET_BITS   = eltu_pkg::DEF_OFFSET_BITS,
	parameter int KEYWORD_CHARS = eltu_pkg::DEF_KEYWORD_CHARS
) (
	input  logic                clk,
	input  logic                arst_n,
	// source byte channel
	input  logic                src_valid,
	output logic                src_stall,
	input  eltu_pkg::src_item_t src_item,
	// token channel
	output logic                tok_valid,
	input  logic                tok_stall,
	output eltu_pkg::token_t    tok_item
);
	import eltu_pkg::*;

	// Stage 1: input register. It holds one source transaction while the
	// scanner decides what it means.
	logic      valid_s1;
	src_item_t item_s1;

	// fire = the held transaction is scanned this cycle and its state
	// update and tokens commit together at the next edge.
	logic      fire;
	logic      room;
	scan_res_t scan_res;

	assign fire = valid_s1 && room;

	// Stall only while the held transaction cannot move on; a free or
	// draining input register takes a new byte every cycle.
	assign src_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_item;
		end
	end

	// Scanner: pending-token state, position counters and the per-byte
	// decision, all between the input register and the result queue.
	eltu_scan #(
		.LINE_BITS     (LINE_BITS),
		.COLUMN_BITS   (COLUMN_BITS),
		.OFFSET_BITS   (OFFSET_BITS),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (scan_res)
	);

	// Result queue: takes up to two tokens a cycle, presents one a cycle.
	// It also acts as the output register, so tok_valid never looks at
	// tok_stall.
	eltu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (scan_res),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

	// a stalled source byte is still held in stage 1 on the next cycle
	`ELTU_ASSERT_NXT(a_stall_holds_s1, src_stall, valid_s1, "held transaction lost")
	// end of input always yields at least the EOI token
	`ELTU_ASSERT_IMP(a_eoi_emits, fire && item_s1.end_of_input, scan_res.count != 2'd0,
		"end of input produced no token")
	// with two tokens, only the second closes the run
	`ELTU_ASSERT_IMP(a_last_marks, scan_res.count == 2'd2,
		scan_res.tok[1].last_of_run && !scan_res.tok[0].last_of_run,
		"last_of_run on wrong token")

endmodule

>>> hw/rtl/eltu_fifo.sv
`include "expression_language_tokenizer_unit_assert.svh"

module eltu_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  eltu_pkg::scan_res_t push,
	output logic               room,
	output logic               tok_valid,
	input  logic               tok_stall,
	output eltu_pkg::token_t   tok_item
);
	import eltu_pkg::*;

	token_t     mem [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	// two free slots guarantee any scan result fits
	assign room      = (cnt_q <= 3'd2);
	assign tok_valid = (cnt_q != 3'd0);
	assign pop       = tok_valid && !tok_stall;
	assign tok_item  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_ptr_q] <= push.tok[0];
		end
		if (push.count == 2'd2) begin
			mem[wr_ptr_q + 2'd1] <= push.tok[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.count;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push.count} - {2'b0, pop};
		end
	end

	`ELTU_ASSERT(a_fifo_bound, cnt_q <= 3'd4, "result queue overflow")
	`ELTU_ASSERT_IMP(a_push_with_room, push.count != 2'd0, cnt_q <= 3'd2,
		"push without two free slots")
	`ELTU_ASSERT_IMP(a_pop_nonempty, pop, cnt_q != 3'd0, "pop from empty result queue")

endmodule

>>> hw/rtl/eltu_scan.sv
module eltu_scan #(
	parameter int LINE_BITS     = eltu_pkg::DEF_LINE_BITS,
	parameter int COLUMN_BITS   = eltu_pkg::DEF_COLUMN_BITS,
	parameter int OFFSET_BITS   = eltu_pkg::DEF_OFFSET_BITS,
	parameter int KEYWORD_CHARS = eltu_pkg::DEF_KEYWORD_CHARS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  eltu_pkg::src_item_t item,
	output eltu_pkg::scan_res_t res
);
	import eltu_pkg::*;

	localparam int PFX_BITS = 8 * KEYWORD_CHARS;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BANG   = 8'h21;

	typedef enum logic [2:0] {
		PK_NONE, PK_MINUS, PK_EQ, PK_LT, PK_GT, PK_BANG, PK_INT, PK_IDENT
	} pend_kind_t;

	logic [LINE_BITS-1:0]   line_q, line_n, tline_q, tline_n;
	logic [COLUMN_BITS-1:0] col_q, col_n, tcol_q, tcol_n;
	logic [OFFSET_BITS-1:0] off_q, off_n, toff_q, toff_n;
	logic [15:0]            tlen_q, tlen_n;
	logic [PFX_BITS-1:0]    pfx_q, pfx_n;
	pend_kind_t             pend_q, pend_n;
	logic                   halted_q, halted_n;

	logic [7:0]  c;
	logic        eoi;
	logic        is_space, is_digit, is_alpha, extend;
	logic [15:0] app_len;
	logic [4:0]  tag2, flush_tag, fr_single;
	pend_kind_t  fr_kind;
	token_t      flush_tok, eoi_tok;
	logic        consume, start_new, do_append;

	function automatic token_t mk_tok(
		input logic [4:0]             tag,
		input logic [LINE_BITS-1:0]   ln,
		input logic [COLUMN_BITS-1:0] cl,
		input logic [OFFSET_BITS-1:0] of,
		input logic [15:0]            len
	);
		token_t t;
		t.token_tag    = tag;
		t.start_line   = 16'(ln);
		t.start_column = 16'(cl);
		t.start_offset = 32'(of);
		t.token_length = len;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	assign c        = item.source_byte;
	assign eoi      = item.end_of_input;
	assign is_space = c inside {8'h20, [8'h09:8'h0D]};
	assign is_digit = c inside {[8'h30:8'h39]};
	assign is_alpha = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	assign extend   = (pend_q == PK_INT && is_digit) ||
		(pend_q == PK_IDENT && (is_digit || is_alpha));
	assign app_len  = (tlen_q == 16'hFFFF) ? tlen_q : tlen_q + 16'd1;

	// two-character operators that close the pending one
	always_comb begin
		tag2 = TAG_EOI;
		if (c == CH_EQ) begin
			case (pend_q)
				PK_EQ:   tag2 = TAG_EQEQ;
				PK_LT:   tag2 = TAG_LE;
				PK_GT:   tag2 = TAG_GE;
				PK_BANG: tag2 = TAG_NE;
				default: tag2 = TAG_EOI;
			endcase
		end else if (c == CH_GT && pend_q == PK_MINUS) begin
			tag2 = TAG_ARROW;
		end
	end

	always_comb begin
		case (pend_q)
			PK_MINUS: flush_tag = TAG_MINUS;
			PK_EQ:    flush_tag = TAG_ASSIGN;
			PK_LT:    flush_tag = TAG_LT;
			PK_GT:    flush_tag = TAG_GT;
			PK_INT:   flush_tag = TAG_INT;
			PK_IDENT: flush_tag = kw_tag(pfx_q[39:0], tlen_q);
			default:  flush_tag = TAG_ERROR;
		endcase
	end

	assign flush_tok = mk_tok(flush_tag, tline_q, tcol_q, toff_q,
		(pend_q == PK_BANG) ? 16'd0 : tlen_q);
	assign eoi_tok   = mk_tok(TAG_EOI, line_q, col_q, off_q, 16'd0);

	// classification of a byte that starts something new
	always_comb begin
		fr_single = TAG_EOI;
		fr_kind   = PK_NONE;
		case (c)
			CH_PLUS:   fr_single = TAG_PLUS;
			CH_STAR:   fr_single = TAG_STAR;
			CH_SLASH:  fr_single = TAG_SLASH;
			CH_LPAREN: fr_single = TAG_LPAREN;
			CH_RPAREN: fr_single = TAG_RPAREN;
			CH_COMMA:  fr_single = TAG_COMMA;
			CH_MINUS:  fr_kind   = PK_MINUS;
			CH_EQ:     fr_kind   = PK_EQ;
			CH_LT:     fr_kind   = PK_LT;
			CH_GT:     fr_kind   = PK_GT;
			CH_BANG:   fr_kind   = PK_BANG;
			default: begin
				if (is_digit) fr_kind = PK_INT;
				else if (is_alpha) fr_kind = PK_IDENT;
			end
		endcase
	end

	always_comb begin
		line_n    = line_q;
		col_n     = col_q;
		off_n     = off_q;
		tline_n   = tline_q;
		tcol_n    = tcol_q;
		toff_n    = toff_q;
		tlen_n    = tlen_q;
		pfx_n     = pfx_q;
		pend_n    = pend_q;
		halted_n  = halted_q;
		res       = '0;
		consume   = 1'b0;
		start_new = 1'b0;
		do_append = 1'b0;

		if (eoi) begin
			if (!halted_q && pend_q != PK_NONE) begin
				res.tok[0] = flush_tok;
				res.tok[1] = eoi_tok;
				res.count  = 2'd2;
			end else begin
				res.tok[0] = eoi_tok;
				res.count  = 2'd1;
			end
			// back to the reset state for the next source
			line_n   = LINE_BITS'(1);
			col_n    = COLUMN_BITS'(1);
			off_n    = '0;
			tline_n  = LINE_BITS'(1);
			tcol_n   = COLUMN_BITS'(1);
			toff_n   = '0;
			tlen_n   = '0;
			pfx_n    = '0;
			pend_n   = PK_NONE;
			halted_n = 1'b0;
		end else if (!halted_q) begin
			if (tag2 != TAG_EOI) begin
				do_append  = 1'b1;
				consume    = 1'b1;
				pend_n     = PK_NONE;
				res.tok[0] = mk_tok(tag2, tline_q, tcol_q, toff_q, app_len);
				res.count  = 2'd1;
			end else if (extend) begin
				do_append = 1'b1;
				consume   = 1'b1;
			end else begin
				if (pend_q != PK_NONE) begin
					res.tok[0] = flush_tok;
					res.count  = 2'd1;
					pend_n     = PK_NONE;
				end
				if (pend_q == PK_BANG) begin
					// lone bang: error already emitted, byte left unconsumed
					halted_n = 1'b1;
				end else if (fr_single != TAG_EOI) begin
					res.tok[res.count[0]] = mk_tok(fr_single, line_q, col_q, off_q, 16'd1);
					res.count = res.count + 2'd1;
					consume   = 1'b1;
				end else if (fr_kind != PK_NONE) begin
					start_new = 1'b1;
					pend_n    = fr_kind;
					consume   = 1'b1;
				end else if (is_space) begin
					consume = 1'b1;
				end else begin
					res.tok[res.count[0]] = mk_tok(TAG_ERROR, line_q, col_q, off_q, 16'd0);
					res.count = res.count + 2'd1;
					halted_n  = 1'b1;
				end
			end
		end

		if (start_new) begin
			tline_n = line_q;
			tcol_n  = col_q;
			toff_n  = off_q;
			tlen_n  = 16'd1;
			pfx_n   = PFX_BITS'(c);
		end else if (do_append) begin
			tlen_n = app_len;
			for (int i = 0; i < KEYWORD_CHARS; i++) begin
				if (tlen_q == 16'(i)) pfx_n[8*i +: 8] = c;
			end
		end

		if (consume) begin
			off_n = off_q + OFFSET_BITS'(1);
			if (c == CH_NL) begin
				if (line_q != '1) line_n = line_q + LINE_BITS'(1);
				col_n = COLUMN_BITS'(1);
			end else if (col_q != '1) begin
				col_n = col_q + COLUMN_BITS'(1);
			end
		end

		if (res.count == 2'd1) res.tok[0].last_of_run = 1'b1;
		if (res.count == 2'd2) res.tok[1].last_of_run = 1'b1;
		if (!fire) res.count = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= LINE_BITS'(1);
			col_q    <= COLUMN_BITS'(1);
			off_q    <= '0;
			tline_q  <= LINE_BITS'(1);
			tcol_q   <= COLUMN_BITS'(1);
			toff_q   <= '0;
			tlen_q   <= '0;
			pfx_q    <= '0;
			pend_q   <= PK_NONE;
			halted_q <= 1'b0;
		end else if (fire) begin
			line_q   <= line_n;
			col_q    <= col_n;
			off_q    <= off_n;
			tline_q  <= tline_n;
			tcol_q   <= tcol_n;
			toff_q   <= toff_n;
			tlen_q   <= tlen_n;
			pfx_q    <= pfx_n;
			pend_q   <= pend_n;
			halted_q <= halted_n;
		end
	end

endmodule

>>> tb/expression_language_tokenizer_unit_tb.sv
import eltu_pkg::*;

typedef enum logic [2:0] {
	OPEN_NONE, OPEN_MINUS, OPEN_EQ, OPEN_LT, OPEN_GT, OPEN_BANG, OPEN_INT, OPEN_IDENT
} open_kind_t;

class lexer_scoreboard;
	localparam int SHOW_LIMIT = 40;

	token_t tokens_due[$];
	int mismatches;
	int shown;
	int checked;

	logic [15:0] line_no, col_no;
	logic [31:0] byte_pos;
	open_kind_t  open_kind;
	logic [15:0] tok_line, tok_col, tok_len;
	logic [31:0] tok_pos;
	logic [39:0] head_chars;
	bit          halted;

	logic [39:0] kw_heads[14];
	logic [4:0]  kw_tags[14];

	function new();
		string words[14] = '{"let", "in", "if", "then", "else", "true", "false",
			"and", "or", "not", "fun", "i32", "bool", "void"};
		foreach (words[i]) begin
			kw_heads[i] = '0;
			for (int j = 0; j < words[i].len(); j++) kw_heads[i][8*j +: 8] = words[i][j];
		end
		kw_tags = '{TAG_LET, TAG_IN, TAG_IF, TAG_THEN, TAG_ELSE, TAG_BOOL_LIT, TAG_BOOL_LIT,
			TAG_AND, TAG_OR, TAG_NOT, TAG_FUN, TAG_I32, TAG_BOOL, TAG_VOID};
		rewind();
	endfunction

	function void rewind();
		line_no    = 16'd1;
		col_no     = 16'd1;
		byte_pos   = '0;
		open_kind  = OPEN_NONE;
		tok_line   = 16'd1;
		tok_col    = 16'd1;
		tok_pos    = '0;
		tok_len    = '0;
		head_chars = '0;
		halted     = 1'b0;
	endfunction

	function bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function void push_token(logic [4:0] tag, logic [15:0] ln, logic [15:0] col,
			logic [31:0] pos, logic [15:0] len);
		token_t t;
		t.token_tag    = tag;
		t.start_line   = ln;
		t.start_column = col;
		t.start_offset = pos;
		t.token_length = len;
		t.last_of_run  = 1'b0;
		tokens_due.push_back(t);
	endfunction

	function void advance(logic [7:0] c);
		byte_pos++;
		if (c == "\n") begin
			if (line_no != 16'hFFFF) line_no++;
			col_no = 16'd1;
		end else if (col_no != 16'hFFFF) begin
			col_no++;
		end
	endfunction

	function void append(logic [7:0] c);
		if (tok_len < 16'd5) head_chars[8*tok_len +: 8] = c;
		if (tok_len != 16'hFFFF) tok_len++;
		advance(c);
	endfunction

	function void open_token(open_kind_t kind, logic [7:0] c);
		open_kind  = kind;
		tok_line   = line_no;
		tok_col    = col_no;
		tok_pos    = byte_pos;
		tok_len    = '0;
		head_chars = '0;
		append(c);
	endfunction

	// emit whatever is held, as it stands
	function void flush_open();
		logic [4:0] tag;
		tag = TAG_IDENT;
		case (open_kind)
			OPEN_NONE: return;
			OPEN_MINUS: tag = TAG_MINUS;
			OPEN_EQ: tag = TAG_ASSIGN;
			OPEN_LT: tag = TAG_LT;
			OPEN_GT: tag = TAG_GT;
			OPEN_INT: tag = TAG_INT;
			OPEN_BANG: begin
				tag     = TAG_ERROR;
				tok_len = '0;
				halted  = 1'b1;
			end
			default: begin
				// keyword only if the whole word fits the held head
				if (tok_len <= 16'd5) begin
					foreach (kw_heads[i]) begin
						if (head_chars == kw_heads[i]) tag = kw_tags[i];
					end
				end
			end
		endcase
		push_token(tag, tok_line, tok_col, tok_pos, tok_len);
		open_kind = OPEN_NONE;
	endfunction

	// Predict the tokens of one accepted transaction; returns 0 if the byte is ignored.
	function bit take_byte(src_item_t it);
		logic [7:0] c;
		logic [4:0] joined, single;
		token_t     last;
		bit         live;
		int         first;
		c      = it.source_byte;
		live   = it.end_of_input || !halted;
		first  = tokens_due.size();
		joined = TAG_EOI;
		single = TAG_EOI;
		if (it.end_of_input) begin
			if (!halted) flush_open();
			push_token(TAG_EOI, line_no, col_no, byte_pos, 16'd0);
			rewind();
		end else if (!halted) begin
			if (c == "=") begin
				case (open_kind)
					OPEN_EQ: joined = TAG_EQEQ;
					OPEN_LT: joined = TAG_LE;
					OPEN_GT: joined = TAG_GE;
					OPEN_BANG: joined = TAG_NE;
					default: ;
				endcase
			end else if (c == ">" && open_kind == OPEN_MINUS) begin
				joined = TAG_ARROW;
			end
			if (joined != TAG_EOI) begin
				append(c);
				push_token(joined, tok_line, tok_col, tok_pos, tok_len);
				open_kind = OPEN_NONE;
			end else if ((open_kind == OPEN_INT && is_digit(c)) ||
					(open_kind == OPEN_IDENT && (is_digit(c) || is_alpha(c)))) begin
				append(c);
			end else begin
				flush_open();
				if (!halted) begin
					case (c)
						"+": single = TAG_PLUS;
						"*": single = TAG_STAR;
						"/": single = TAG_SLASH;
						"(": single = TAG_LPAREN;
						")": single = TAG_RPAREN;
						",": single = TAG_COMMA;
						"-": open_token(OPEN_MINUS, c);
						"=": open_token(OPEN_EQ, c);
						"<": open_token(OPEN_LT, c);
						">": open_token(OPEN_GT, c);
						"!": open_token(OPEN_BANG, c);
						default: begin
							if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
								advance(c);
							end else if (is_digit(c)) begin
								open_token(OPEN_INT, c);
							end else if (is_alpha(c)) begin
								open_token(OPEN_IDENT, c);
							end else begin
								// bad byte: error token, not consumed
								push_token(TAG_ERROR, line_no, col_no, byte_pos, 16'd0);
								halted = 1'b1;
							end
						end
					endcase
					if (single != TAG_EOI) begin
						push_token(single, line_no, col_no, byte_pos, 16'd1);
						advance(c);
					end
				end
			end
		end
		if (tokens_due.size() > first) begin
			last = tokens_due.pop_back();
			last.last_of_run = 1'b1;
			tokens_due.push_back(last);
		end
		return live;
	endfunction

	task report(string what);
		if (shown < SHOW_LIMIT) $display("mismatch at %0t: %s", $time, what);
		shown++;
		mismatches++;
	endtask

	task check_token(token_t got);
		token_t want;
		checked++;
		if (tokens_due.size() == 0) begin
			report($sformatf("token %0d (tag %0d) arrived with none due", checked,
				got.token_tag));
			return;
		end
		want = tokens_due.pop_front();
		if (got.token_tag !== want.token_tag)
			report($sformatf("token %0d tag %0d, want %0d", checked, got.token_tag,
				want.token_tag));
		if (got.start_line !== want.start_line)
			report($sformatf("token %0d line %0d, want %0d", checked, got.start_line,
				want.start_line));
		if (got.start_column !== want.start_column)
			report($sformatf("token %0d column %0d, want %0d", checked, got.start_column,
				want.start_column));
		if (got.start_offset !== want.start_offset)
			report($sformatf("token %0d offset %0d, want %0d", checked, got.start_offset,
				want.start_offset));
		if (got.token_length !== want.token_length)
			report($sformatf("token %0d length %0d, want %0d", checked, got.token_length,
				want.token_length));
		if (got.last_of_run !== want.last_of_run)
			report($sformatf("token %0d last_of_run %0b, want %0b", checked, got.last_of_run,
				want.last_of_run));
	endtask
endclass

module expression_language_tokenizer_unit_tb;
	localparam int HOLD_CYCLES   = 400;        // long output hold to back the block up
	localparam int CYCLE_LIMIT   = 2_000_000;  // watchdog, far above the slowest good run
	localparam int SETTLE_CYCLES = 10;         // input register and result queue drain, with slack
	localparam int RANDOM_ITEMS  = 480;        // live source bytes in the random part

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_stall;
	src_item_t src_item;
	logic      tok_valid;
	logic      tok_stall;
	token_t    tok_item;

	lexer_scoreboard sb = new();

	bit calm;          // both sides skip their random gaps while set
	bit hold_req;      // asks the token side for one long hold
	int cycles     = 0;
	int live_items = 0;
	int sources    = 0;

	string op_text[15] = '{"+", "-", "->", "*", "/", "=", "==", "<", "<=", ">", ">=", "!=",
		"(", ")", ","};
	// keywords plus near misses: wrong length, wrong case, keyword prefixes
	string word_text[24] = '{"let", "in", "if", "then", "else", "true", "false", "and", "or",
		"not", "fun", "i32", "bool", "void", "lets", "fals", "falsey", "i3", "voids", "If",
		"TRUE", "iff", "x", "n0"};
	logic [7:0] blank_chars[6] = '{" ", "\t", "\n", "\r", 8'h0B, 8'h0C};

	expression_language_tokenizer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Token monitor: a transaction completes on an edge with valid high and stall low.
	// Values are read before this edge's updates land, so there is no race with the DUT.
	always @(posedge clk) begin
		if (arst_n && tok_valid && !tok_stall) sb.check_token(tok_item);
	end

	// Token side stall: a fresh random wait before each transaction,
	// none at all while calm, and one long hold when hold_req is raised.
	initial begin
		int n;
		tok_stall = 1'b0;
		forever begin
			if (hold_req) begin
				tok_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				n = calm ? 0 : $urandom_range(0, 9);
				if (n > 0) begin
					tok_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			tok_stall <= 1'b0;
			do @(posedge clk); while (!tok_valid);
		end
	end

	function automatic logic [7:0] char_of(int k);
		if (k < 10) return 8'("0" + k);
		if (k < 36) return 8'("a" + k - 10);
		return 8'("A" + k - 36);
	endfunction

	// One source transaction. Valid stays high from one item to the next when there is
	// no gap, so it never gets two updates in one step; the payload holds while stalled.
	task automatic send_byte(input logic [7:0] b, input bit eoi);
		int        gap;
		src_item_t it;
		gap             = calm ? 0 : $urandom_range(0, 9);
		it.source_byte  = b;
		it.end_of_input = eoi;
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		do @(posedge clk); while (src_stall);
		if (sb.take_byte(it)) live_items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	// end of input carries a random byte, which must be ignored
	task automatic send_eoi();
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		sources++;
	endtask

	// Mostly well-formed text: operators, numbers, words, blanks. Neighbors may merge
	// (ident+digits, '-' then '>'), which exercises the pending-token flush. A rare
	// lone bang or raw byte usually halts the source until end of input.
	task automatic send_random_source();
		int lexemes;
		int pick;
		lexemes = $urandom_range(0, 30);
		for (int i = 0; i < lexemes; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 32) begin
				send_text(op_text[$urandom_range(0, 14)]);
			end else if (pick < 50) begin
				repeat ($urandom_range(1, 5)) send_byte(char_of($urandom_range(0, 9)), 1'b0);
			end else if (pick < 67) begin
				send_text(word_text[$urandom_range(0, 23)]);
			end else if (pick < 79) begin
				send_byte(char_of($urandom_range(10, 61)), 1'b0);
				repeat ($urandom_range(0, 7)) send_byte(char_of($urandom_range(0, 61)), 1'b0);
			end else if (pick < 98) begin
				send_byte(blank_chars[$urandom_range(0, 5)], 1'b0);
			end else if (pick < 99) begin
				send_byte("!", 1'b0);
			end else begin
				send_byte(8'($urandom_range(0, 255)), 1'b0);
			end
			if ($urandom_range(0, 1) == 0) send_byte(blank_chars[$urandom_range(0, 5)], 1'b0);
		end
		send_eoi();
	endtask

	// source side pauses until every predicted token is back, then lets the pipe settle
	task automatic wait_drained();
		src_valid <= 1'b0;
		while (sb.tokens_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_item  = '0;
		calm      = 1'b0;
		hold_req  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every operator tag but >=, an int, a five-letter keyword flushed by end of
		// input, a lone bang followed by an ignored byte, and a byte above 127.
		send_text("(<=,-)*/==+<> = ->!=9 false");
		send_eoi();
		send_text("!a");
		send_eoi();
		send_byte(8'h80, 1'b0);
		send_eoi();
		wait_drained();

		// Back-pressure: token side holds while sources stream in with no gaps,
		// so the result queue fills and the block stalls its input.
		calm     = 1'b1;
		hold_req = 1'b1;
		repeat (3) send_random_source();
		calm = 1'b0;
		wait_drained();

		// Random part; some sources run without any idling on either side.
		live_items = 0;
		while (live_items < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			send_random_source();
		end
		calm = 1'b0;
		wait_drained();

		$display("covered %0d sources, %0d live bytes in the random part, %0d tokens compared",
			sources, live_items, sb.checked);
		$display("included directed operator and error sources and a %0d-cycle output hold",
			HOLD_CYCLES);
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
